// File: hdl/spd3_pkg.sv
// Shared constants, types and latency helpers for the 3x3 SPD inverse.
package spd3_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Latency of one multiply-subtract unit (magnitudes, partials, round, subtract).
	localparam int MSUB_LAT = 4;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic vld;  // head entry present
		logic bad;  // first pivot is zero or negative
	} head_t;

	// Divider latency: operand load, one stage per quotient bit, round, clamp.
	function automatic int div_lat(int w, int f);
		return w + f + 3;
	endfunction

endpackage

// File: hdl/spd3_dly.sv
// Enabled shift line that delays a vector by a fixed number of stages.
module spd3_dly #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sh_q [DEPTH];

	// shift on every enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				sh_q[k] <= sh_q[k-1];
			end
		end
	end

	assign q = sh_q[DEPTH-1];

endmodule

// File: hdl/spd3_msub.sv
// Pipelined fixed-point multiply-subtract: y = sat(c - sat(round(a*b))).
module spd3_msub #(
	parameter int DATA_WIDTH = spd3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = spd3_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DATA_WIDTH-1:0] c,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] y
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int LO = W / 2;
	localparam int HI = W - LO;
	localparam int PW = 2 * W;

	logic [W-1:0]        ma_s1, mb_s1;
	logic                neg_s1, neg_s2;
	logic signed [W-1:0] c_s1, c_s2, c_s3, p_s3;
	logic [2*LO-1:0]     pll_s2;
	logic [LO+HI-1:0]    plh_s2, phl_s2;
	logic [2*HI-1:0]     phh_s2;
	logic [PW-1:0]       prod, rnd, mag, lim, sat;
	logic [W-1:0]        pv;
	logic signed [W-1:0] p_nx, y_nx;
	logic [W:0]          diff;

	// product magnitude with rounding to nearest, ties away, then clamp
	always_comb begin
		prod = PW'(pll_s2) + (PW'(plh_s2) << LO) + (PW'(phl_s2) << LO)
			+ (PW'(phh_s2) << (2 * LO));
		rnd  = prod + (PW'(1) << (F - 1));
		mag  = rnd >> F;
		lim  = neg_s2 ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
		sat  = (mag > lim) ? lim : mag;
		pv   = sat[W-1:0];
		p_nx = neg_s2 ? -pv : pv;
	end

	// saturating subtract
	always_comb begin
		diff = {c_s3[W-1], c_s3} - {p_s3[W-1], p_s3};
		if (diff[W] != diff[W-1]) begin
			y_nx = diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			y_nx = diff[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: sign and magnitudes
			neg_s1 <= a[W-1] ^ b[W-1];
			ma_s1  <= a[W-1] ? -a : a;
			mb_s1  <= b[W-1] ? -b : b;
			c_s1   <= c;
			// s2: half-width partial products
			pll_s2 <= ma_s1[LO-1:0] * mb_s1[LO-1:0];
			plh_s2 <= ma_s1[LO-1:0] * mb_s1[W-1:LO];
			phl_s2 <= ma_s1[W-1:LO] * mb_s1[LO-1:0];
			phh_s2 <= ma_s1[W-1:LO] * mb_s1[W-1:LO];
			neg_s2 <= neg_s1;
			c_s2   <= c_s1;
			// s3: rounded, saturated product
			p_s3   <= p_nx;
			c_s3   <= c_s2;
			// s4: result
			y      <= y_nx;
		end
	end

endmodule

// File: hdl/spd3_div.sv
// Pipelined restoring divider: y = sat(round(a * 2^F / b)), b taken as positive.
module spd3_div #(
	parameter int DATA_WIDTH = spd3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = spd3_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] y
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NW = W + F;

	logic [NW-1:0] num_s [NW+1];
	logic [W-1:0]  rem_s [NW+1];
	logic [W-1:0]  mb_s  [NW+1];
	logic          neg_s [NW+1];
	logic [W:0]    t_c   [NW];
	logic          ge_c  [NW];
	logic [W-1:0]  ma;
	logic [W:0]    rem_e;
	logic          up;
	logic [NW:0]   q_r, lim, qsat;
	logic          neg_r;
	logic [W-1:0]  mag;

	assign ma = a[W-1] ? -a : a;

	// one quotient bit per stage
	always_comb begin
		for (int k = 0; k < NW; k++) begin
			t_c[k]  = {rem_s[k], num_s[k][NW-1]};
			ge_c[k] = t_c[k] >= {1'b0, mb_s[k]};
		end
	end

	// round half away from zero on the remainder
	always_comb begin
		rem_e = {1'b0, rem_s[NW]};
		up    = rem_e >= ({1'b0, mb_s[NW]} - rem_e);
	end

	// clamp to the signed range
	always_comb begin
		lim  = neg_r ? ((NW+1)'(1) << (W - 1)) : (((NW+1)'(1) << (W - 1)) - (NW+1)'(1));
		qsat = (q_r > lim) ? lim : q_r;
		mag  = qsat[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= {ma, {F{1'b0}}};
			rem_s[0] <= '0;
			mb_s[0]  <= b;
			neg_s[0] <= a[W-1];
			for (int k = 0; k < NW; k++) begin
				rem_s[k+1] <= ge_c[k] ? W'(t_c[k] - {1'b0, mb_s[k]}) : t_c[k][W-1:0];
				num_s[k+1] <= {num_s[k][NW-2:0], ge_c[k]};
				mb_s[k+1]  <= mb_s[k];
				neg_s[k+1] <= neg_s[k];
			end
			q_r   <= (NW+1)'(num_s[NW]) + (NW+1)'(up);
			neg_r <= neg_s[NW];
			y     <= neg_r ? -mag : mag;
		end
	end

endmodule

// File: hdl/spd3_front.sv
// Front end: input register, first-pivot check and a two-entry queue.
module spd3_front #(
	parameter int DATA_WIDTH = spd3_pkg::DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      m_valid,
	output logic                      m_stall,
	input  logic [6*DATA_WIDTH-1:0]   m_in,
	output spd3_pkg::head_t           head,
	output logic [6*DATA_WIDTH-1:0]   head_data,
	input  logic                      pop
);

	import spd3_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int DW = 6 * W;

	logic          v_s1, bad_s1;
	logic [DW-1:0] dat_s1;
	logic [DW-1:0] qdat_q [2];
	logic          qbad_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          full, push;

	assign full    = cnt_q == 2'd2;
	assign push    = v_s1 && !full;
	assign m_stall = v_s1 && full;

	assign head.vld  = cnt_q != 2'd0;
	assign head.bad  = qbad_q[rp_q];
	assign head_data = qdat_q[rp_q];

	// control: input register valid, queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (!m_stall) v_s1 <= m_valid;
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// beat capture with pivot check, queue write
	always_ff @(posedge clk) begin
		if (!m_stall && m_valid) begin
			dat_s1 <= m_in;
			bad_s1 <= m_in[W-1] || (m_in[W-1:0] == '0);
		end
		if (push) begin
			qdat_q[wp_q] <= dat_s1;
			qbad_q[wp_q] <= bad_s1;
		end
	end

endmodule

// File: hdl/spd3_back.sv
// Back end: LDL' factorization and three column solves in a stalling pipeline.
module spd3_back #(
	parameter int DATA_WIDTH = spd3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = spd3_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spd3_pkg::head_t         head,
	input  logic [6*DATA_WIDTH-1:0] head_data,
	output logic                    pop,
	input  logic                    inv_stall,
	output logic                    inv_valid,
	output logic [9*DATA_WIDTH-1:0] inv,
	output logic                    not_definite
);

	import spd3_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int LM = MSUB_LAT;
	localparam int LD = div_lat(W, F);
	localparam int T4 = 2 * LD + 2 * LM;
	localparam int T8 = 3 * LD + 5 * LM;
	localparam logic [W-1:0] ONE = (F >= W - 1) ? {1'b0, {(W-1){1'b1}}} : (W'(1) << F);

	logic                en;
	logic [T8:0]         vld_q;
	logic                out_v_q;
	logic [6*W-1:0]      m_s1;
	logic                bad_s1;
	logic [9*W-1:0]      res, inv_q;
	logic                nd_q, nd4, nd8, bad0_d, d1n_d;
	logic signed [W-1:0] m00, m10, m11, m20, m21, m22;
	logic [5*W-1:0]      mdl;
	logic signed [W-1:0] l10, l20, l21, d1, d2p, a21, d2;
	logic [2*W-1:0]      fdl;
	logic signed [W-1:0] l10_f, l20_f, l21_f, l10_b, l20_b, l21_b;
	logic signed [W-1:0] d0_d, d1_d, d2_d;

	assign m00 = m_s1[0*W +: W];
	assign m10 = m_s1[1*W +: W];
	assign m11 = m_s1[2*W +: W];
	assign m20 = m_s1[3*W +: W];
	assign m21 = m_s1[4*W +: W];
	assign m22 = m_s1[5*W +: W];

	// whole pipeline moves unless the output register is held
	assign en  = !out_v_q || !inv_stall;
	assign pop = en && head.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[T8-1:0], head.vld};
			out_v_q <= vld_q[T8];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= head_data;
			bad_s1 <= head.bad;
			inv_q  <= nd8 ? '0 : res;
			nd_q   <= nd8;
		end
	end

	assign inv_valid    = out_v_q;
	assign inv          = inv_q;
	assign not_definite = nd_q;

	// factorization: first column of L
	spd3_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_l20 (.clk, .en, .a(m20), .b(m00), .y(l20));
	spd3_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_l10 (.clk, .en, .a(m10), .b(m00), .y(l10));
	spd3_dly #(.WIDTH(5*W), .DEPTH(LD)) u_dm (.clk, .en,
		.d({m10, m11, m20, m21, m22}), .q(mdl));

	// Schur updates
	spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_d2p (.clk, .en,
		.c(mdl[0*W +: W]), .a(mdl[2*W +: W]), .b(l20), .y(d2p));
	spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_a21 (.clk, .en,
		.c(mdl[1*W +: W]), .a(mdl[4*W +: W]), .b(l20), .y(a21));
	spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_d1 (.clk, .en,
		.c(mdl[3*W +: W]), .a(mdl[4*W +: W]), .b(l10), .y(d1));

	// second column of L and last pivot
	spd3_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_l21 (.clk, .en, .a(a21), .b(d1), .y(l21));
	spd3_dly #(.WIDTH(2*W), .DEPTH(LD)) u_da (.clk, .en, .d({d2p, a21}), .q(fdl));
	spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_d2 (.clk, .en,
		.c(fdl[W +: W]), .a(fdl[0 +: W]), .b(l21), .y(d2));

	// factor alignment for the column solves
	spd3_dly #(.WIDTH(2*W), .DEPTH(LD+LM)) u_dlf (.clk, .en,
		.d({l10, l20}), .q({l10_f, l20_f}));
	spd3_dly #(.WIDTH(W), .DEPTH(LM)) u_d21f (.clk, .en, .d(l21), .q(l21_f));
	spd3_dly #(.WIDTH(W), .DEPTH(2*LD+3*LM)) u_d20b (.clk, .en, .d(l20), .q(l20_b));
	spd3_dly #(.WIDTH(W), .DEPTH(2*LD+4*LM)) u_d10b (.clk, .en, .d(l10), .q(l10_b));
	spd3_dly #(.WIDTH(W), .DEPTH(LD+2*LM)) u_d21b (.clk, .en, .d(l21), .q(l21_b));
	spd3_dly #(.WIDTH(W), .DEPTH(2*LD+3*LM)) u_dd0 (.clk, .en, .d(m00), .q(d0_d));
	spd3_dly #(.WIDTH(W), .DEPTH(LD+2*LM)) u_dd1 (.clk, .en, .d(d1), .q(d1_d));
	spd3_dly #(.WIDTH(W), .DEPTH(LM)) u_dd2 (.clk, .en, .d(d2), .q(d2_d));

	// pivot flags, merged once the last pivot is known
	spd3_dly #(.WIDTH(1), .DEPTH(T4)) u_db0 (.clk, .en, .d(bad_s1), .q(bad0_d));
	spd3_dly #(.WIDTH(1), .DEPTH(LD+LM)) u_db1 (.clk, .en,
		.d(d1[W-1] || (d1 == '0)), .q(d1n_d));
	assign nd4 = bad0_d || d1n_d || d2[W-1] || (d2 == '0);
	spd3_dly #(.WIDTH(1), .DEPTH(LD+3*LM)) u_db2 (.clk, .en, .d(nd4), .q(nd8));

	// one solve per identity column
	for (genvar j = 0; j < 3; j++) begin : g_col
		localparam logic [W-1:0] X0 = (j == 0) ? ONE : '0;
		localparam logic [W-1:0] X1 = (j == 1) ? ONE : '0;
		localparam logic [W-1:0] X2 = (j == 2) ? ONE : '0;

		logic signed [W-1:0] y1, y2a, y2, y1_d, z0, z1, z2, w1, w0a, w0, w1_d, z2_d;

		// forward substitution
		spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_y1 (.clk, .en,
			.c(X1), .a(l10_f), .b(X0), .y(y1));
		spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_y2a (.clk, .en,
			.c(X2), .a(l20_f), .b(X0), .y(y2a));
		spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_y2 (.clk, .en,
			.c(y2a), .a(l21_f), .b(y1), .y(y2));
		spd3_dly #(.WIDTH(W), .DEPTH(LM)) u_dy1 (.clk, .en, .d(y1), .q(y1_d));

		// diagonal scaling
		spd3_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_z0 (.clk, .en, .a(X0), .b(d0_d), .y(z0));
		spd3_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_z1 (.clk, .en, .a(y1_d), .b(d1_d), .y(z1));
		spd3_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_z2 (.clk, .en, .a(y2), .b(d2_d), .y(z2));

		// back substitution
		spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_w1 (.clk, .en,
			.c(z1), .a(l21_b), .b(z2), .y(w1));
		spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_w0a (.clk, .en,
			.c(z0), .a(l20_b), .b(z2), .y(w0a));
		spd3_msub #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_w0 (.clk, .en,
			.c(w0a), .a(l10_b), .b(w1), .y(w0));
		spd3_dly #(.WIDTH(W), .DEPTH(LM)) u_dw1 (.clk, .en, .d(w1), .q(w1_d));
		spd3_dly #(.WIDTH(W), .DEPTH(2*LM)) u_dz2 (.clk, .en, .d(z2), .q(z2_d));

		assign res[(0*3+j)*W +: W] = w0;
		assign res[(1*3+j)*W +: W] = w1_d;
		assign res[(2*3+j)*W +: W] = z2_d;
	end

endmodule

// File: hdl/spd3_matrix_inverse.sv
// Top level of the symmetric positive definite 3x3 matrix inverse.
// Takes one matrix beat per clock while m_stall is low and returns one beat of
// nine inverse entries per clock, in order, while inv_stall is low. Entries are
// in Q16.16 at the default widths. The critical path runs through three
// dependent pipelined dividers (first column of L, l21, the diagonal scaling),
// each one stage per quotient bit, plus five multiply-subtract steps of four
// stages. A two-entry queue sits between the input register and the datapath;
// a stalled result freezes the datapath and the queue absorbs two more beats.
// A pivot of zero or less sets not_definite and forces all entries to zero.
module spd3_matrix_inverse #(
	parameter int DATA_WIDTH = spd3_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = spd3_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         m_valid,
	output logic                         m_stall,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic                         inv_valid,
	input  logic                         inv_stall,
	output logic signed [DATA_WIDTH-1:0] inv00,
	output logic signed [DATA_WIDTH-1:0] inv01,
	output logic signed [DATA_WIDTH-1:0] inv02,
	output logic signed [DATA_WIDTH-1:0] inv10,
	output logic signed [DATA_WIDTH-1:0] inv11,
	output logic signed [DATA_WIDTH-1:0] inv12,
	output logic signed [DATA_WIDTH-1:0] inv20,
	output logic signed [DATA_WIDTH-1:0] inv21,
	output logic signed [DATA_WIDTH-1:0] inv22,
	output logic                         not_definite
);

	import spd3_pkg::*;

	localparam int W = DATA_WIDTH;

	head_t          head;
	logic [6*W-1:0] head_data;
	logic           pop;
	logic [9*W-1:0] inv;

	spd3_front #(.DATA_WIDTH(W)) u_front (
		.clk, .arst_n, .m_valid, .m_stall,
		.m_in({m22, m21, m20, m11, m10, m00}),
		.head, .head_data, .pop
	);

	spd3_back #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .head, .head_data, .pop,
		.inv_stall, .inv_valid, .inv, .not_definite
	);

	// result fields, row then column
	assign inv00 = inv[0*W +: W];
	assign inv01 = inv[1*W +: W];
	assign inv02 = inv[2*W +: W];
	assign inv10 = inv[3*W +: W];
	assign inv11 = inv[4*W +: W];
	assign inv12 = inv[5*W +: W];
	assign inv20 = inv[6*W +: W];
	assign inv21 = inv[7*W +: W];
	assign inv22 = inv[8*W +: W];

endmodule

// File: hdl/spd3_chk.sv
// Port-level checker for the SPD inverse, bound to the top level.
module spd3_chk #(
	parameter int DATA_WIDTH = spd3_pkg::DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_valid,
	input logic                         m_stall,
	input logic signed [DATA_WIDTH-1:0] m00,
	input logic signed [DATA_WIDTH-1:0] m10,
	input logic signed [DATA_WIDTH-1:0] m11,
	input logic signed [DATA_WIDTH-1:0] m20,
	input logic signed [DATA_WIDTH-1:0] m21,
	input logic signed [DATA_WIDTH-1:0] m22,
	input logic                         inv_valid,
	input logic                         inv_stall,
	input logic signed [DATA_WIDTH-1:0] inv00,
	input logic signed [DATA_WIDTH-1:0] inv01,
	input logic signed [DATA_WIDTH-1:0] inv02,
	input logic signed [DATA_WIDTH-1:0] inv10,
	input logic signed [DATA_WIDTH-1:0] inv11,
	input logic signed [DATA_WIDTH-1:0] inv12,
	input logic signed [DATA_WIDTH-1:0] inv20,
	input logic signed [DATA_WIDTH-1:0] inv21,
	input logic signed [DATA_WIDTH-1:0] inv22,
	input logic                         not_definite
);

	// reset empties the datapath and frees the input side
	a_rst: assert property (@(posedge clk) !arst_n |=> !inv_valid && !m_stall)
		else $error("result beat or input stall right after reset");

	// a singular or indefinite matrix gives an all-zero inverse
	a_nd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && not_definite |->
		inv00 == 0 && inv01 == 0 && inv02 == 0 && inv10 == 0 && inv11 == 0 &&
		inv12 == 0 && inv20 == 0 && inv21 == 0 && inv22 == 0)
		else $error("nonzero inverse entry with not_definite set");

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_stall |=> inv_valid)
		else $error("result beat dropped under stall");

	// a stalled result beat does not change
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		inv_valid && inv_stall |=> $stable({inv00, inv01, inv02, inv10, inv11,
		inv12, inv20, inv21, inv22, not_definite}))
		else $error("result beat changed under stall");

endmodule

bind spd3_matrix_inverse spd3_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (.*);

// File: tb/spd3_matrix_inverse_tb.sv
// Self-checking testbench for the 3x3 SPD inverse: directed, random and back-pressure tests.
module spd3_matrix_inverse_tb;

	localparam int DW = spd3_pkg::DATA_WIDTH_DEF;
	localparam int FB = spd3_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = 3 * (DW + FB) + 32;
	localparam int IDLE_LIMIT = 20 * LATENCY + 2000;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;

	typedef logic signed [DW-1:0] fx_t;

	localparam fx_t FX_MAX = fx_t'(MAXV);
	localparam fx_t FX_MIN = fx_t'(MINV);

	typedef struct {
		fx_t inv [9];
		logic nd;
	} inverse_t;

	logic clk;
	logic arst_n;
	logic m_valid;
	logic m_stall;
	fx_t m00, m10, m11, m20, m21, m22;
	logic inv_valid;
	logic inv_stall;
	fx_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
	logic not_definite;

	inverse_t expected_q[$];
	int n_sent;
	int n_checked;
	int n_singular;
	int n_errors;
	int idle_cycles;
	bit allow_idle;

	spd3_matrix_inverse dut (
		.clk(clk), .arst_n(arst_n),
		.m_valid(m_valid), .m_stall(m_stall),
		.m00(m00), .m10(m10), .m11(m11), .m20(m20), .m21(m21), .m22(m22),
		.inv_valid(inv_valid), .inv_stall(inv_stall),
		.inv00(inv00), .inv01(inv01), .inv02(inv02),
		.inv10(inv10), .inv11(inv11), .inv12(inv12),
		.inv20(inv20), .inv21(inv21), .inv22(inv22),
		.not_definite(not_definite)
	);

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Fixed-point arithmetic, rounded half away from zero, saturated
	function automatic longint sat(logic signed [127:0] v);
		if (v > MAXV) return MAXV;
		if (v < MINV) return MINV;
		return longint'(v);
	endfunction

	function automatic longint fx_sub(longint a, longint b);
		logic signed [127:0] s;
		s = 128'(a) - 128'(b);
		return sat(s);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] mg;
		bit neg;
		p = 128'(a) * 128'(b);
		neg = p < 0;
		mg = neg ? -p : p;
		mg = (mg + (128'd1 << (FB - 1))) >> FB;
		return sat(neg ? -$signed(mg) : $signed(mg));
	endfunction

	function automatic longint fx_div(longint a, longint b);
		logic [127:0] n, q, r;
		bit neg;
		neg = a < 0;
		n = (neg ? 128'(-128'(a)) : 128'(a)) << FB;
		q = n / 128'(b);
		r = n % 128'(b);
		if (r >= 128'(b) - r) q = q + 1;
		return sat(neg ? -$signed(q) : $signed(q));
	endfunction

	// LDL' factorization and column solves
	function automatic inverse_t ldlt_inverse(fx_t a00, fx_t a10, fx_t a11,
			fx_t a20, fx_t a21, fx_t a22);
		inverse_t r;
		longint d0, d1, d2, l10, l20, l21, c21, x0, x1, x2;
		longint v10, v11, v20, v21, v22;
		r.nd = 1'b1;
		for (int k = 0; k < 9; k++) r.inv[k] = '0;
		d0 = longint'(a00);
		v10 = longint'(a10);
		v11 = longint'(a11);
		v20 = longint'(a20);
		v21 = longint'(a21);
		v22 = longint'(a22);
		if (d0 <= 0) return r;
		l20 = fx_div(v20, d0);
		d2 = fx_sub(v22, fx_mul(v20, l20));
		c21 = fx_sub(v21, fx_mul(v10, l20));
		l10 = fx_div(v10, d0);
		d1 = fx_sub(v11, fx_mul(v10, l10));
		if (d1 <= 0) return r;
		l21 = fx_div(c21, d1);
		d2 = fx_sub(d2, fx_mul(c21, l21));
		if (d2 <= 0) return r;
		r.nd = 1'b0;
		for (int j = 0; j < 3; j++) begin
			x0 = (j == 0) ? (longint'(1) << FB) : 0;
			x1 = (j == 1) ? (longint'(1) << FB) : 0;
			x2 = (j == 2) ? (longint'(1) << FB) : 0;
			x1 = fx_sub(x1, fx_mul(l10, x0));
			x2 = fx_sub(x2, fx_mul(l20, x0));
			x2 = fx_sub(x2, fx_mul(l21, x1));
			x0 = fx_div(x0, d0);
			x1 = fx_div(x1, d1);
			x2 = fx_div(x2, d2);
			x1 = fx_sub(x1, fx_mul(l21, x2));
			x0 = fx_sub(x0, fx_mul(l20, x2));
			x0 = fx_sub(x0, fx_mul(l10, x1));
			r.inv[j] = fx_t'(x0);
			r.inv[3 + j] = fx_t'(x1);
			r.inv[6 + j] = fx_t'(x2);
		end
		return r;
	endfunction

	// Send one matrix beat, with optional idle burst first
	task automatic send_matrix(fx_t a00, fx_t a10, fx_t a11, fx_t a20, fx_t a21, fx_t a22);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			m_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		m_valid <= 1'b1;
		m00 <= a00; m10 <= a10; m11 <= a11;
		m20 <= a20; m21 <= a21; m22 <= a22;
		@(posedge clk);
		while (m_stall) @(posedge clk);
		expected_q.push_back(ldlt_inverse(a00, a10, a11, a20, a21, a22));
		n_sent++;
	endtask

	task automatic go_quiet();
		m_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		go_quiet();
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Output stall bursts
	initial begin
		inv_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (allow_idle && inv_stall == 1'b0 && $urandom_range(0, 3) == 0) begin
				inv_stall <= 1'b1;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else begin
				inv_stall <= 1'b0;
			end
		end
	end

	// Result check against oldest expectation
	always @(posedge clk) begin
		inverse_t e;
		fx_t got [9];
		if (arst_n && inv_valid && !inv_stall) begin
			got = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				n_errors++;
			end else begin
				e = expected_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== e.inv[k]) begin
						$display("%0t: inv%0d%0d expected %0d actual %0d",
							$time, k / 3, k % 3, e.inv[k], got[k]);
						n_errors++;
					end
				if (not_definite !== e.nd) begin
					$display("%0t: not_definite expected %0b actual %0b",
						$time, e.nd, not_definite);
					n_errors++;
				end
				if (e.nd) n_singular++;
				n_checked++;
			end
		end
	end

	// Watchdog on cycles with no beat accepted
	always @(posedge clk) begin
		if ((m_valid && !m_stall) || (inv_valid && !inv_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("spd3_matrix_inverse_tb: FAIL");
			$finish;
		end
	end

	function automatic fx_t rnd_fx();
		return fx_t'($urandom);
	endfunction

	// Well-conditioned SPD matrix: diagonal dominant, random off-diagonals
	task automatic send_random_spd(int span);
		fx_t o10, o20, o21;
		o10 = $signed($urandom_range(0, 2 * span)) - span;
		o20 = $signed($urandom_range(0, 2 * span)) - span;
		o21 = $signed($urandom_range(0, 2 * span)) - span;
		send_matrix(fx_t'(3 * span + $urandom_range(1, span)), o10,
			fx_t'(3 * span + $urandom_range(1, span)), o20, o21,
			fx_t'(3 * span + $urandom_range(1, span)));
	endtask

	task automatic test_directed();
		send_matrix(32'sh10000, 0, 32'sh10000, 0, 0, 32'sh10000);
		send_matrix(32'sh20000, 32'sh8000, 32'sh30000, 32'sh4000, 32'sh2000, 32'sh40000);
		send_matrix(0, 0, 32'sh10000, 0, 0, 32'sh10000);
		send_matrix(FX_MIN, FX_MAX, FX_MAX, FX_MIN, FX_MAX, FX_MIN);
		send_matrix(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000);
		send_matrix(32'sh10000, 32'sh10000, 32'sh8000, 0, 0, 32'sh10000);
		send_matrix(32'sh10000, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000);
		send_matrix(32'sh10000, 0, 32'sh10000, 0, 0, -1);
		send_matrix(1, 0, 1, 0, 0, 1);
		send_matrix(FX_MAX, 0, FX_MAX, 0, 0, FX_MAX);
		send_matrix(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
		send_matrix(FX_MAX, FX_MIN + 1, FX_MAX, 0, 0, FX_MAX);
		send_matrix(32'sh100, 32'sh80, 32'sh100, -32'sh80, 32'sh40, 32'sh100);
		send_matrix(2, 1, 2, -1, 1, 2);
		send_matrix(1, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX);
		send_matrix(FX_MAX, 1, 1, 1, 1, 1);
		send_matrix(32'shFFFF, -1, 32'sh7FFF_0000, 0, -1, 32'sh1);
		send_matrix(FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MIN, FX_MAX);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			case ($urandom_range(0, 9))
				0: send_matrix(rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx());
				1: send_random_spd(1 << $urandom_range(0, 30));
				2: send_random_spd($urandom_range(1, 64));
				default: send_random_spd(1 << $urandom_range(8, 24));
			endcase
	endtask

	task automatic test_pause_until_empty();
		drain();
		test_random(20);
		drain();
	endtask

	task automatic test_full_rate();
		allow_idle = 1'b0;
		test_random(60);
	endtask

	initial begin
		m_valid = 1'b0;
		{m00, m10, m11, m20, m21, m22} = '0;
		n_sent = 0; n_checked = 0; n_singular = 0; n_errors = 0;
		idle_cycles = 0;
		allow_idle = 1'b1;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_random(300);
		test_pause_until_empty();
		test_full_rate();
		drain();
		repeat (LATENCY) @(posedge clk);
		$display("Covered %0d matrices, %0d results checked, %0d flagged not definite.",
			n_sent, n_checked, n_singular);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("spd3_matrix_inverse_tb: PASS");
		else
			$display("spd3_matrix_inverse_tb: FAIL");
		$finish;
	end

endmodule
